// ===== hdl/fsgb_pkg.sv =====
package fsgb_pkg;

  // field widths of the feed message and the result
  localparam int CMD_W = 2;
  localparam int SYM_W = 8;
  localparam int SEQ_W = 64;
  localparam int PX_W  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_SNAPSHOT = 2'd0,
    CMD_UPDATE   = 2'd1,
    CMD_TRADE    = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  // per-symbol status bits, cleared after reset
  typedef struct packed {
    logic anchored;
    logic stale;
  } flags_t;

  typedef struct packed {
    logic [PX_W-1:0] bid_px;
    logic [PX_W-1:0] bid_qty;
    logic [PX_W-1:0] ask_px;
    logic [PX_W-1:0] ask_qty;
  } book_t;

  // per-symbol sequence and top of book, undefined until a snapshot
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    book_t            book;
  } entry_t;

  typedef struct packed {
    logic             accepted;
    logic             gap_detected;
    logic [SEQ_W-1:0] expected_sequence;
    logic             anchored;
    logic             stale;
    book_t            book;
  } res_t;

endpackage

// ===== hdl/fsgb_if.sv =====
// message channel into the table
interface fsgb_in_if;
  logic                         valid;
  logic                         ready;
  logic [fsgb_pkg::CMD_W-1:0]   cmd;
  logic [fsgb_pkg::SYM_W-1:0]   symbol;
  logic [fsgb_pkg::SEQ_W-1:0]   sequence_req;
  logic [fsgb_pkg::PX_W-1:0]    bid_px;
  logic [fsgb_pkg::PX_W-1:0]    bid_qty;
  logic [fsgb_pkg::PX_W-1:0]    ask_px;
  logic [fsgb_pkg::PX_W-1:0]    ask_qty;

  modport source (
    output valid, cmd, symbol, sequence_req, bid_px, bid_qty, ask_px, ask_qty,
    input  ready
  );
  modport sink (
    input  valid, cmd, symbol, sequence_req, bid_px, bid_qty, ask_px, ask_qty,
    output ready
  );
endinterface

// result channel out of the table
interface fsgb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic                         gap_detected;
  logic [fsgb_pkg::SEQ_W-1:0]   expected_sequence;
  logic                         anchored;
  logic                         stale;
  logic [fsgb_pkg::PX_W-1:0]    out_bid_px;
  logic [fsgb_pkg::PX_W-1:0]    out_bid_qty;
  logic [fsgb_pkg::PX_W-1:0]    out_ask_px;
  logic [fsgb_pkg::PX_W-1:0]    out_ask_qty;

  modport source (
    output valid, accepted, gap_detected, expected_sequence, anchored, stale,
           out_bid_px, out_bid_qty, out_ask_px, out_ask_qty,
    input  ready
  );
  modport sink (
    input  valid, accepted, gap_detected, expected_sequence, anchored, stale,
           out_bid_px, out_bid_qty, out_ask_px, out_ask_qty,
    output ready
  );
endinterface

// ===== hdl/fsgb_ram.sv =====
module fsgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read; a read of the entry being written returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/feed_sequence_gap_book_table_unit.sv =====
// path: an accepted request waits in s1 during the table read, then its result is
//   registered; throughput: one request per cycle while the output is not stalled,
//   also for the same symbol back to back, as the prior result is forwarded
// reset: after rst_n goes high a clearing pass over every entry zeroes the
//   status table; in_chan.ready stays low until it ends
module feed_sequence_gap_book_table_unit #(
  parameter int NUM_SYMBOLS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  fsgb_in_if.sink     in_chan,
  fsgb_out_if.source  out_chan
);

  localparam int ADDR_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int EXT_W   = (ADDR_W > fsgb_pkg::SYM_W) ? ADDR_W : fsgb_pkg::SYM_W;
  localparam int FLAGS_W = $bits(fsgb_pkg::flags_t);
  localparam int ENTRY_W = $bits(fsgb_pkg::entry_t);

  // clearing pass over the status table
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              clr_last;

  // request in flight while its table read completes
  logic                  s1_valid_r;
  logic                  s1_in_range_r;
  fsgb_pkg::cmd_t        s1_cmd_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic [fsgb_pkg::SEQ_W-1:0] s1_seq_r;
  fsgb_pkg::book_t       s1_book_r;

  // last write, for a read that overlapped it
  logic                  fwd_hit_r;
  fsgb_pkg::flags_t      fwd_flags_r;
  fsgb_pkg::entry_t      fwd_entry_r;

  // result register
  logic                  out_valid_r;
  fsgb_pkg::res_t        out_res_r;

  logic                  in_accept;
  logic                  s1_adv;
  logic                  s1_wr;
  logic [EXT_W-1:0]      in_sym_ext;
  logic [ADDR_W-1:0]     in_addr;
  logic                  in_range;

  logic [FLAGS_W-1:0]    flags_rd;
  logic [ENTRY_W-1:0]    entry_rd;
  logic                  flags_we;
  logic [ADDR_W-1:0]     flags_waddr;
  fsgb_pkg::flags_t      flags_wdata;

  fsgb_pkg::flags_t      flags_cur;
  fsgb_pkg::entry_t      entry_cur;
  fsgb_pkg::flags_t      flags_nxt;
  fsgb_pkg::entry_t      entry_nxt;
  fsgb_pkg::res_t        res_nxt;
  logic [fsgb_pkg::SEQ_W-1:0] seq_plus1;
  logic                  seq_newer;

  // handshake
  assign in_sym_ext    = EXT_W'(in_chan.symbol);
  assign in_addr       = in_sym_ext[ADDR_W-1:0];
  assign in_range      = (32'(in_chan.symbol) < 32'(NUM_SYMBOLS));
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign s1_wr         = s1_adv && s1_in_range_r;
  assign in_chan.ready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign clr_last      = (clr_cnt_r == ADDR_W'(NUM_SYMBOLS - 1));

  // status table write port, shared with the clearing pass
  always_comb begin
    if (clr_active_r) begin
      flags_we    = 1'b1;
      flags_waddr = clr_cnt_r;
      flags_wdata = '0;
    end else begin
      flags_we    = s1_wr;
      flags_waddr = s1_addr_r;
      flags_wdata = flags_nxt;
    end
  end

  fsgb_ram #(
    .WIDTH (FLAGS_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_flags_ram (
    .clk   (clk),
    .we    (flags_we),
    .waddr (flags_waddr),
    .wdata (flags_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (flags_rd)
  );

  fsgb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_addr_r),
    .wdata (entry_nxt),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (entry_rd)
  );

  // current entry: forwarded when the read overlapped the previous write
  assign flags_cur = fwd_hit_r ? fwd_flags_r : fsgb_pkg::flags_t'(flags_rd);
  assign entry_cur = fwd_hit_r ? fwd_entry_r : fsgb_pkg::entry_t'(entry_rd);
  assign seq_plus1 = entry_cur.seq + 64'd1;
  assign seq_newer = (s1_seq_r > entry_cur.seq);

  // apply the message to the entry and build the result
  always_comb begin
    flags_nxt = flags_cur;
    entry_nxt = entry_cur;
    res_nxt   = '0;
    case (s1_cmd_r)
      fsgb_pkg::CMD_SNAPSHOT: begin
        flags_nxt.anchored = 1'b1;
        flags_nxt.stale    = 1'b0;
        entry_nxt.seq      = s1_seq_r;
        entry_nxt.book     = s1_book_r;
        res_nxt.accepted   = 1'b1;
      end
      fsgb_pkg::CMD_UPDATE, fsgb_pkg::CMD_TRADE: begin
        if (flags_cur.anchored && seq_newer) begin
          if (s1_seq_r != seq_plus1) begin
            flags_nxt.stale           = 1'b1;
            res_nxt.gap_detected      = 1'b1;
            res_nxt.expected_sequence = seq_plus1;
          end
          entry_nxt.seq = s1_seq_r;
          if (s1_cmd_r == fsgb_pkg::CMD_UPDATE) begin
            entry_nxt.book = s1_book_r;
          end
          res_nxt.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_nxt.anchored = flags_nxt.anchored;
    res_nxt.stale    = flags_nxt.stale;
    res_nxt.book     = flags_nxt.anchored ? entry_nxt.book : '0;
    // symbol outside the table: nothing reported
    if (!s1_in_range_r) begin
      res_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        if (clr_last) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_wr && (s1_addr_r == in_addr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_in_range_r     <= in_range;
      s1_cmd_r          <= fsgb_pkg::cmd_t'(in_chan.cmd);
      s1_addr_r         <= in_addr;
      s1_seq_r          <= in_chan.sequence_req;
      s1_book_r.bid_px  <= in_chan.bid_px;
      s1_book_r.bid_qty <= in_chan.bid_qty;
      s1_book_r.ask_px  <= in_chan.ask_px;
      s1_book_r.ask_qty <= in_chan.ask_qty;
    end
    if (s1_wr) begin
      fwd_flags_r <= flags_nxt;
      fwd_entry_r <= entry_nxt;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  // result channel
  assign out_chan.valid             = out_valid_r;
  assign out_chan.accepted          = out_res_r.accepted;
  assign out_chan.gap_detected      = out_res_r.gap_detected;
  assign out_chan.expected_sequence = out_res_r.expected_sequence;
  assign out_chan.anchored          = out_res_r.anchored;
  assign out_chan.stale             = out_res_r.stale;
  assign out_chan.out_bid_px        = out_res_r.book.bid_px;
  assign out_chan.out_bid_qty       = out_res_r.book.bid_qty;
  assign out_chan.out_ask_px        = out_res_r.book.ask_px;
  assign out_chan.out_ask_qty       = out_res_r.book.ask_qty;

endmodule

// ===== hdl/fsgb_checker.sv =====
module fsgb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         accepted,
  input logic                         gap_detected,
  input logic [fsgb_pkg::SEQ_W-1:0]   expected_sequence,
  input logic                         anchored,
  input logic                         stale,
  input logic [fsgb_pkg::PX_W-1:0]    out_bid_px,
  input logic [fsgb_pkg::PX_W-1:0]    out_bid_qty,
  input logic [fsgb_pkg::PX_W-1:0]    out_ask_px,
  input logic [fsgb_pkg::PX_W-1:0]    out_ask_qty
);

  // table clearing holds off requests right after reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("request taken during clearing pass");

  // a gap is only reported on an applied message that leaves the symbol stale
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && gap_detected) |-> (accepted && anchored && stale))
    else $error("gap reported without applied stale entry");

  // no gap, no expected sequence
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !gap_detected) |-> (expected_sequence == '0))
    else $error("expected sequence without gap");

  // an unanchored symbol reports an empty book and no status
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !anchored) |-> (!stale && !accepted && out_bid_px == '0 &&
      out_bid_qty == '0 && out_ask_px == '0 && out_ask_qty == '0))
    else $error("unanchored symbol reports state");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(accepted) &&
      $stable(expected_sequence) && $stable(stale) && $stable(out_bid_px)))
    else $error("stalled result changed");

endmodule

bind feed_sequence_gap_book_table_unit fsgb_checker u_fsgb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .accepted          (out_chan.accepted),
  .gap_detected      (out_chan.gap_detected),
  .expected_sequence (out_chan.expected_sequence),
  .anchored          (out_chan.anchored),
  .stale             (out_chan.stale),
  .out_bid_px        (out_chan.out_bid_px),
  .out_bid_qty       (out_chan.out_bid_qty),
  .out_ask_px        (out_chan.out_ask_px),
  .out_ask_qty       (out_chan.out_ask_qty)
);

// ===== tb/sv/feed_sequence_gap_book_table_unit_test.sv =====
`timescale 1ns / 100ps

module feed_sequence_gap_book_table_unit_test;

  localparam int NUM_SYMBOLS    = 256;
  localparam int MAX_DIFF_LINES = 60;

  // shadow of the symbol table, predicts one result per request
  class gap_book_scoreboard;
    bit                         sym_anchored [NUM_SYMBOLS];
    bit                         sym_stale    [NUM_SYMBOLS];
    bit [fsgb_pkg::SEQ_W-1:0]   sym_last_seq [NUM_SYMBOLS];
    fsgb_pkg::book_t            sym_book     [NUM_SYMBOLS];
    fsgb_pkg::res_t             pending_results [$];
    int                         mismatches;
    int                         checked;
    int                         n_snapshot;
    int                         n_applied;
    int                         n_gap;
    int                         n_dropped;
    int                         n_query;

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_DIFF_LINES)
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // apply an accepted request to the shadow table and queue its result
    function void note_request(fsgb_pkg::cmd_t cmd, bit [fsgb_pkg::SYM_W-1:0] sym,
                               bit [fsgb_pkg::SEQ_W-1:0] seq_no, fsgb_pkg::book_t bk);
      fsgb_pkg::res_t           want;
      bit [fsgb_pkg::SEQ_W-1:0] next_seq;
      want = '0;
      case (cmd)
        fsgb_pkg::CMD_SNAPSHOT: begin
          sym_anchored[sym] = 1'b1;
          sym_stale[sym]    = 1'b0;
          sym_last_seq[sym] = seq_no;
          sym_book[sym]     = bk;
          want.accepted     = 1'b1;
          n_snapshot++;
        end
        fsgb_pkg::CMD_UPDATE, fsgb_pkg::CMD_TRADE: begin
          if (sym_anchored[sym] && seq_no > sym_last_seq[sym]) begin
            next_seq = sym_last_seq[sym] + 64'd1;
            if (seq_no != next_seq) begin
              sym_stale[sym]         = 1'b1;
              want.gap_detected      = 1'b1;
              want.expected_sequence = next_seq;
              n_gap++;
            end
            sym_last_seq[sym] = seq_no;
            if (cmd == fsgb_pkg::CMD_UPDATE)
              sym_book[sym] = bk;
            want.accepted = 1'b1;
            n_applied++;
          end else begin
            n_dropped++;
          end
        end
        default: begin
          n_query++;
        end
      endcase
      want.anchored = sym_anchored[sym];
      want.stale    = sym_stale[sym];
      want.book     = sym_anchored[sym] ? sym_book[sym] : '0;
      pending_results.push_back(want);
    endfunction

    // compare one result with the oldest prediction
    task check_result(fsgb_pkg::res_t got);
      fsgb_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report("result arrived with no request outstanding");
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.accepted !== want.accepted)
        report($sformatf("accepted got %0b want %0b", got.accepted, want.accepted));
      if (got.gap_detected !== want.gap_detected)
        report($sformatf("gap_detected got %0b want %0b", got.gap_detected,
                         want.gap_detected));
      if (got.expected_sequence !== want.expected_sequence)
        report($sformatf("expected_sequence got %h want %h", got.expected_sequence,
                         want.expected_sequence));
      if (got.anchored !== want.anchored)
        report($sformatf("anchored got %0b want %0b", got.anchored, want.anchored));
      if (got.stale !== want.stale)
        report($sformatf("stale got %0b want %0b", got.stale, want.stale));
      if (got.book.bid_px !== want.book.bid_px)
        report($sformatf("bid px got %h want %h", got.book.bid_px, want.book.bid_px));
      if (got.book.bid_qty !== want.book.bid_qty)
        report($sformatf("bid_qty got %h want %h", got.book.bid_qty, want.book.bid_qty));
      if (got.book.ask_px !== want.book.ask_px)
        report($sformatf("ask px got %h want %h", got.book.ask_px, want.book.ask_px));
      if (got.book.ask_qty !== want.book.ask_qty)
        report($sformatf("ask_qty got %h want %h", got.book.ask_qty, want.book.ask_qty));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   stall_pct;
  int   hold_cycles;

  gap_book_scoreboard sb = new();

  fsgb_in_if  in_ch ();
  fsgb_out_if out_ch ();

  feed_sequence_gap_book_table_unit #(
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("feed_sequence_gap_book_table_unit regression: fail");
    $finish;
  end

  // result side: check accepted results, then choose ready for the next cycle
  initial begin
    fsgb_pkg::res_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.accepted          = out_ch.accepted;
        got.gap_detected      = out_ch.gap_detected;
        got.expected_sequence = out_ch.expected_sequence;
        got.anchored          = out_ch.anchored;
        got.stale             = out_ch.stale;
        got.book.bid_px       = out_ch.out_bid_px;
        got.book.bid_qty      = out_ch.out_bid_qty;
        got.book.ask_px       = out_ch.out_ask_px;
        got.book.ask_qty      = out_ch.out_ask_qty;
        sb.check_result(got);
      end
      // long hold-off counted here, otherwise random stalls
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one request, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_request(fsgb_pkg::cmd_t cmd, logic [fsgb_pkg::SYM_W-1:0] sym,
                              logic [fsgb_pkg::SEQ_W-1:0] seq_no, fsgb_pkg::book_t bk,
                              int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.symbol       <= sym;
    in_ch.sequence_req <= seq_no;
    in_ch.bid_px       <= bk.bid_px;
    in_ch.bid_qty      <= bk.bid_qty;
    in_ch.ask_px       <= bk.ask_px;
    in_ch.ask_qty      <= bk.ask_qty;
    @(posedge clk);
    while (in_ch.ready !== 1'b1)
      @(posedge clk);
    sb.note_request(cmd, sym, seq_no, bk);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do
      @(posedge clk);
    while (sb.pending_results.size() != 0);
  endtask

  // mostly in-order feed traffic on a few hot symbols, with gaps, stale
  // sequences and unanchored symbols mixed in
  task automatic send_random_requests(int count, int idle_pct);
    fsgb_pkg::cmd_t             cmd;
    logic [fsgb_pkg::SYM_W-1:0] sym;
    logic [fsgb_pkg::SEQ_W-1:0] seq_no;
    logic [fsgb_pkg::SEQ_W-1:0] base;
    fsgb_pkg::book_t            bk;
    int                         pick;
    int                         hot;
    int                         sym_i;
    repeat (count) begin
      hot = int'($urandom_range(7));
      if ($urandom_range(99) < 75)
        sym_i = (hot < 4) ? hot : 248 + hot;
      else
        sym_i = int'($urandom_range(255));
      sym = sym_i[fsgb_pkg::SYM_W-1:0];

      pick = int'($urandom_range(99));
      if (pick < 12)
        cmd = fsgb_pkg::CMD_SNAPSHOT;
      else if (pick < 55)
        cmd = fsgb_pkg::CMD_UPDATE;
      else if (pick < 85)
        cmd = fsgb_pkg::CMD_TRADE;
      else
        cmd = fsgb_pkg::CMD_QUERY;

      base = sb.sym_anchored[sym] ? sb.sym_last_seq[sym] : {$urandom, $urandom};
      pick = int'($urandom_range(99));
      if (cmd == fsgb_pkg::CMD_SNAPSHOT) begin
        if (pick < 60)
          seq_no = {32'd0, $urandom};
        else if (pick < 80)
          seq_no = {$urandom, $urandom};
        else if (pick < 90)
          seq_no = '1 - 64'($urandom_range(3));
        else
          seq_no = '0;
      end else begin
        if (pick < 70)
          seq_no = base + 64'd1;
        else if (pick < 82)
          seq_no = base + 64'd2 + 64'($urandom_range(1000));
        else if (pick < 92)
          seq_no = base - 64'($urandom_range(3));
        else
          seq_no = {$urandom, $urandom};
      end

      bk.bid_px  = $urandom;
      bk.bid_qty = $urandom;
      bk.ask_px  = $urandom;
      bk.ask_qty = $urandom;
      send_request(cmd, sym, seq_no, bk, idle_pct);
    end
  endtask

  // main sequence
  initial begin
    fsgb_pkg::book_t bk_zero;
    fsgb_pkg::book_t bk_ones;
    fsgb_pkg::book_t bk_mix;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = fsgb_pkg::CMD_QUERY;
    in_ch.symbol       = '0;
    in_ch.sequence_req = '0;
    in_ch.bid_px       = '0;
    in_ch.bid_qty      = '0;
    in_ch.ask_px       = '0;
    in_ch.ask_qty      = '0;
    stall_pct          = 0;
    hold_cycles        = 0;
    bk_zero            = '0;
    bk_ones            = '1;
    bk_mix             = {32'h8000_0001, 32'h7FFF_FFFE, 32'hA5A5_5A5A, 32'h0000_FFFF};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // unanchored symbol: query and dropped messages report zeros
    send_request(fsgb_pkg::CMD_QUERY,    8'd0,   64'd0,   bk_zero, 0);
    send_request(fsgb_pkg::CMD_UPDATE,   8'd0,   64'd5,   bk_ones, 0);
    send_request(fsgb_pkg::CMD_TRADE,    8'd0,   64'd5,   bk_ones, 0);
    // in-order, duplicate, old and gapped sequences on one symbol
    send_request(fsgb_pkg::CMD_SNAPSHOT, 8'd0,   64'd100, bk_ones, 0);
    send_request(fsgb_pkg::CMD_UPDATE,   8'd0,   64'd101, bk_zero, 0);
    send_request(fsgb_pkg::CMD_TRADE,    8'd0,   64'd101, bk_mix,  0);
    send_request(fsgb_pkg::CMD_UPDATE,   8'd0,   64'd50,  bk_mix,  0);
    send_request(fsgb_pkg::CMD_TRADE,    8'd0,   64'd105, bk_mix,  0);
    send_request(fsgb_pkg::CMD_QUERY,    8'd0,   64'd0,   bk_zero, 0);
    send_request(fsgb_pkg::CMD_UPDATE,   8'd0,   64'd106, bk_mix,  0);
    // a fresh snapshot clears the stale mark
    send_request(fsgb_pkg::CMD_SNAPSHOT, 8'd0,   64'd0,   bk_zero, 0);
    send_request(fsgb_pkg::CMD_TRADE,    8'd0,   64'd1,   bk_ones, 0);
    // maximum stored sequence blocks every later update and trade
    send_request(fsgb_pkg::CMD_SNAPSHOT, 8'd255, '1 - 64'd1, bk_mix, 0);
    send_request(fsgb_pkg::CMD_TRADE,    8'd255, '1,      bk_ones, 0);
    send_request(fsgb_pkg::CMD_UPDATE,   8'd255, '1,      bk_zero, 0);
    send_request(fsgb_pkg::CMD_TRADE,    8'd255, '1,      bk_zero, 0);
    send_request(fsgb_pkg::CMD_QUERY,    8'd255, '1,      bk_ones, 0);
    // widest possible gap and a carry across bit 63
    send_request(fsgb_pkg::CMD_SNAPSHOT, 8'd128, 64'd0,   bk_ones, 0);
    send_request(fsgb_pkg::CMD_UPDATE,   8'd128, '1,      bk_mix,  0);
    send_request(fsgb_pkg::CMD_SNAPSHOT, 8'd1,   64'h7FFF_FFFF_FFFF_FFFF, bk_mix, 0);
    send_request(fsgb_pkg::CMD_UPDATE,   8'd1,   64'h8000_0000_0000_0000, bk_ones, 0);
    send_request(fsgb_pkg::CMD_QUERY,    8'd2,   64'd0,   bk_zero, 0);
    send_request(fsgb_pkg::CMD_SNAPSHOT, 8'hAA,  64'hAAAA_AAAA_AAAA_AAAA, bk_mix, 0);
    send_request(fsgb_pkg::CMD_UPDATE,   8'h55,  64'h5555_5555_5555_5555, bk_mix, 0);

    // random traffic under the different idling mixes
    stall_pct = 0;
    send_random_requests(200, 0);
    send_random_requests(140, 52);
    stall_pct = 52;
    send_random_requests(140, 0);
    stall_pct = 20;
    send_random_requests(140, 20);

    // receiver holds off while the sender keeps pushing, then a full drain
    stall_pct   = 0;
    hold_cycles = 400;
    send_random_requests(100, 0);
    wait_for_drain();
    stall_pct = 30;
    send_random_requests(40, 30);

    wait_for_drain();
    repeat (10) @(posedge clk);

    $display("checked %0d results: %0d snapshots, %0d applied updates/trades, %0d gaps,",
             sb.checked, sb.n_snapshot, sb.n_applied, sb.n_gap);
    $display("%0d dropped messages and %0d queries, with back-pressure on both sides",
             sb.n_dropped, sb.n_query);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("feed_sequence_gap_book_table_unit regression: pass");
    end else begin
      $display("feed_sequence_gap_book_table_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fsgb_pkg.sv
hdl/fsgb_if.sv
hdl/fsgb_ram.sv
hdl/feed_sequence_gap_book_table_unit.sv
hdl/fsgb_checker.sv
tb/sv/feed_sequence_gap_book_table_unit_test.sv
